[hw/rtl/hpn_pkg.sv]
// shared types and constants for the hashed palette nearest color block
package hpn_pkg;

  localparam int unsigned ChanW = 8;
  localparam int unsigned DistW = 22;

  typedef enum logic [1:0] {
    REQ_CLEAR   = 2'd0,
    REQ_INSTALL = 2'd1,
    REQ_BUILD   = 2'd2,
    REQ_QUERY   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RSVD  = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_HEAD,
    ST_IRD,
    ST_INEXT,
    ST_IFILL,
    ST_BRD,
    ST_BHEAD,
    ST_BSRD,
    ST_BD0,
    ST_BD1,
    ST_BCMP,
    ST_QRD,
    ST_QCHK,
    ST_QD1,
    ST_QCMP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [ChanW-1:0] idx;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } slot_t;

endpackage

[hw/rtl/hpn_dist.sv]
// two-stage color distance unit, squared or channel weighted
module hpn_dist (
  input  logic                     clk_i,
  input  logic                     weighted_i,
  input  logic [hpn_pkg::ChanW-1:0] ref_r_i,
  input  logic [hpn_pkg::ChanW-1:0] ref_g_i,
  input  logic [hpn_pkg::ChanW-1:0] ref_b_i,
  input  hpn_pkg::slot_t           slot_i,
  output logic [hpn_pkg::DistW-1:0] dist_o
);
  import hpn_pkg::*;

  logic [ChanW-1:0]   dr, dg, db;
  logic [2*ChanW-1:0] sq_r_q, sq_g_q, sq_b_q;
  logic               wt_q;
  logic [DistW-1:0]   dist_d, dist_q;

  always_comb begin
    dr = (ref_r_i >= slot_i.red)   ? ref_r_i - slot_i.red   : slot_i.red - ref_r_i;
    dg = (ref_g_i >= slot_i.green) ? ref_g_i - slot_i.green : slot_i.green - ref_g_i;
    db = (ref_b_i >= slot_i.blue)  ? ref_b_i - slot_i.blue  : slot_i.blue - ref_b_i;
  end

  always_ff @(posedge clk_i) begin
    sq_r_q <= dr * dr;
    sq_g_q <= dg * dg;
    sq_b_q <= db * db;
    wt_q   <= weighted_i;
    dist_q <= dist_d;
  end

  // 9x and 36x by shift and add
  always_comb begin
    if (wt_q) begin
      dist_d = (DistW'(sq_r_q) << 3) + DistW'(sq_r_q)
             + (DistW'(sq_g_q) << 5) + (DistW'(sq_g_q) << 2)
             + DistW'(sq_b_q);
    end else begin
      dist_d = DistW'(sq_r_q) + DistW'(sq_g_q) + DistW'(sq_b_q);
    end
  end

  assign dist_o = dist_q;

endmodule

[hw/rtl/hashed_palette_nearest_color.sv]
// top level: palette store, bucket heads, request sequencer
// Each request gives exactly one result beat. A query walks its bucket's chain and keeps the
// closest entry, or returns a lone entry without a distance check; an install walks its
// bucket's chain to the end and links the new slot there; a build gives each empty bucket
// the installed slot nearest its corner color, found with the two-stage distance unit.
// The result beat waits in its own output register, so the next request is taken while
// it waits and only stalls at completion. After reset and after each clear request the
// bucket head memory is swept one entry a cycle with no request taken.
module hashed_palette_nearest_color #(
  parameter int unsigned MAX_COLORS = 256,
  parameter int unsigned RED_BITS   = 3,
  parameter int unsigned GREEN_BITS = 3,
  parameter int unsigned BLUE_BITS  = 2
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                req_type_i,
  input  logic [hpn_pkg::ChanW-1:0] color_index_i,
  input  logic [hpn_pkg::ChanW-1:0] red_i,
  input  logic [hpn_pkg::ChanW-1:0] green_i,
  input  logic [hpn_pkg::ChanW-1:0] blue_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [hpn_pkg::ChanW-1:0] result_color_o,
  output logic [1:0]                result_status_o
);
  import hpn_pkg::*;

  localparam int unsigned CodeW = RED_BITS + GREEN_BITS + BLUE_BITS;
  localparam int unsigned NumBuckets = 1 << CodeW;
  localparam int unsigned SlotW = $clog2(MAX_COLORS);
  localparam int unsigned CntW = $clog2(MAX_COLORS + 1);
  localparam int unsigned LinkW = SlotW + 1;

  state_e state_q, state_d;

  logic [LinkW-1:0] head_mem [NumBuckets];
  logic [LinkW-1:0] next_mem [MAX_COLORS];
  slot_t            data_mem [MAX_COLORS];

  logic [LinkW-1:0] head_rd_q, next_rd_q;
  slot_t            data_rd_q;
  logic [CodeW-1:0] head_raddr, head_waddr;
  logic [LinkW-1:0] head_wdata, next_wdata;
  logic [SlotW-1:0] data_raddr, next_waddr;
  logic             head_we, next_we, data_we;

  logic             mode_q;
  req_e             req_q, req_d;
  logic [ChanW-1:0] cidx_q, cidx_d, red_q, red_d, green_q, green_d, blue_q, blue_d;
  logic [CntW-1:0]  count_q, count_d, steps_q, steps_d;
  logic [CodeW-1:0] code_q, code_d, clr_q, clr_d, req_code;
  logic             clr_req_q, clr_req_d, first_q, first_d;
  logic [SlotW-1:0] cur_q, cur_d, best_slot_q, best_slot_d, new_slot;
  logic [LinkW-1:0] nxt_q, nxt_d;
  logic [ChanW-1:0] idx_q, idx_d, best_idx_q, best_idx_d;
  logic [DistW-1:0] bestd_q, bestd_d, cand_dist;
  logic [ChanW-1:0] res_color_q, res_color_d;
  logic [1:0]       res_status_q, res_status_d;
  logic [ChanW-1:0] out_color_q, out_color_d;
  logic [1:0]       out_status_q, out_status_d;
  logic             out_valid_q, out_valid_d;
  logic [ChanW-1:0] ref_r, ref_g, ref_b;
  logic             is_build, closer;
  logic [CntW-1:0]  steps_inc;

  assign req_code = {red_q[ChanW-1 -: RED_BITS], green_q[ChanW-1 -: GREEN_BITS],
                     blue_q[ChanW-1 -: BLUE_BITS]};
  assign new_slot = count_q[SlotW-1:0];
  assign is_build = (req_q == REQ_BUILD);
  assign steps_inc = steps_q + CntW'(1);
  assign closer = (cand_dist < bestd_q);

  // bucket corner color for build, request color otherwise
  always_comb begin
    if (is_build) begin
      ref_r = {code_q[CodeW-1 -: RED_BITS], {(ChanW-RED_BITS){1'b0}}};
      ref_g = {code_q[BLUE_BITS +: GREEN_BITS], {(ChanW-GREEN_BITS){1'b0}}};
      ref_b = {code_q[0 +: BLUE_BITS], {(ChanW-BLUE_BITS){1'b0}}};
    end else begin
      ref_r = red_q;
      ref_g = green_q;
      ref_b = blue_q;
    end
  end

  hpn_dist u_dist (
    .clk_i      (clk_i),
    .weighted_i (mode_q),
    .ref_r_i    (ref_r),
    .ref_g_i    (ref_g),
    .ref_b_i    (ref_b),
    .slot_i     (data_rd_q),
    .dist_o     (cand_dist)
  );

  always_comb begin
    head_raddr = is_build ? code_q : req_code;
    data_raddr = is_build ? steps_q[SlotW-1:0] : cur_q;
  end

  always_ff @(posedge clk_i) begin
    head_rd_q <= head_mem[head_raddr];
    next_rd_q <= next_mem[cur_q];
    data_rd_q <= data_mem[data_raddr];
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    if (data_we) begin
      data_mem[new_slot] <= '{idx: cidx_q, red: red_q, green: green_q, blue: blue_q};
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (&clr_q) state_d = clr_req_q ? ST_DONE : ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (req_q)
          REQ_CLEAR:   state_d = ST_CLEAR;
          REQ_INSTALL: state_d = (count_q == CntW'(MAX_COLORS)) ? ST_DONE : ST_HEAD;
          REQ_BUILD:   state_d = (count_q == '0) ? ST_DONE : ST_BRD;
          REQ_QUERY:   state_d = ST_HEAD;
          default:     state_d = ST_DONE;
        endcase
      end
      ST_HEAD: begin
        if (req_q == REQ_INSTALL) begin
          state_d = head_rd_q[SlotW] ? ST_IRD : ST_IFILL;
        end else begin
          state_d = head_rd_q[SlotW] ? ST_QRD : ST_DONE;
        end
      end
      ST_IRD: state_d = ST_INEXT;
      ST_INEXT: begin
        if (next_rd_q[SlotW] && steps_q < CntW'(MAX_COLORS)) state_d = ST_IRD;
        else state_d = ST_IFILL;
      end
      ST_IFILL: state_d = ST_DONE;
      ST_BRD:   state_d = ST_BHEAD;
      ST_BHEAD: begin
        if (!head_rd_q[SlotW]) state_d = ST_BSRD;
        else if (&code_q) state_d = ST_DONE;
        else state_d = ST_BRD;
      end
      ST_BSRD: state_d = ST_BD0;
      ST_BD0:  state_d = ST_BD1;
      ST_BD1:  state_d = ST_BCMP;
      ST_BCMP: begin
        if (steps_inc < count_q) state_d = ST_BSRD;
        else if (&code_q) state_d = ST_DONE;
        else state_d = ST_BRD;
      end
      ST_QRD: state_d = ST_QCHK;
      ST_QCHK: begin
        state_d = (first_q && !next_rd_q[SlotW]) ? ST_DONE : ST_QD1;
      end
      ST_QD1: state_d = ST_QCMP;
      ST_QCMP: begin
        if (nxt_q[SlotW] && steps_inc < CntW'(MAX_COLORS)) state_d = ST_QRD;
        else state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    req_d = req_q;
    cidx_d = cidx_q;
    red_d = red_q;
    green_d = green_q;
    blue_d = blue_q;
    count_d = count_q;
    steps_d = steps_q;
    code_d = code_q;
    clr_d = clr_q;
    clr_req_d = clr_req_q;
    first_d = first_q;
    cur_d = cur_q;
    nxt_d = nxt_q;
    idx_d = idx_q;
    best_idx_d = best_idx_q;
    best_slot_d = best_slot_q;
    bestd_d = bestd_q;
    res_color_d = res_color_q;
    res_status_d = res_status_q;
    out_color_d = out_color_q;
    out_status_d = out_status_q;
    out_valid_d = out_valid_q;
    head_we = 1'b0;
    head_waddr = req_code;
    head_wdata = {1'b1, new_slot};
    next_we = 1'b0;
    next_waddr = cur_q;
    next_wdata = {1'b1, new_slot};
    data_we = 1'b0;
    in_ready_o = 1'b0;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        head_we = 1'b1;
        head_waddr = clr_q;
        head_wdata = '0;
        clr_d = clr_q + CodeW'(1);
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_d = req_e'(req_type_i);
          cidx_d = color_index_i;
          red_d = red_i;
          green_d = green_i;
          blue_d = blue_i;
        end
      end
      ST_DECODE: begin
        res_color_d = '0;
        res_status_d = STAT_OK;
        code_d = '0;
        clr_d = '0;
        clr_req_d = 1'b1;
        steps_d = '0;
        first_d = 1'b1;
        bestd_d = '1;
        if (req_q == REQ_CLEAR) count_d = '0;
        if (req_q == REQ_INSTALL && count_q == CntW'(MAX_COLORS)) begin
          res_status_d = STAT_FULL;
        end
      end
      ST_HEAD: begin
        cur_d = head_rd_q[SlotW-1:0];
        if (req_q == REQ_INSTALL) begin
          if (!head_rd_q[SlotW]) head_we = 1'b1;
        end else if (!head_rd_q[SlotW]) begin
          res_status_d = STAT_EMPTY;
        end
      end
      ST_IRD: ;
      ST_INEXT: begin
        if (next_rd_q[SlotW] && steps_q < CntW'(MAX_COLORS)) begin
          cur_d = next_rd_q[SlotW-1:0];
          steps_d = steps_inc;
        end else begin
          next_we = 1'b1;
        end
      end
      ST_IFILL: begin
        next_we = 1'b1;
        next_waddr = new_slot;
        next_wdata = '0;
        data_we = 1'b1;
        count_d = count_q + CntW'(1);
      end
      ST_BRD: ;
      ST_BHEAD: begin
        steps_d = '0;
        bestd_d = '1;
        best_slot_d = '0;
        if (head_rd_q[SlotW]) code_d = code_q + CodeW'(1);
      end
      ST_BSRD: ;
      ST_BD0: ;
      ST_BD1: ;
      ST_BCMP: begin
        steps_d = steps_inc;
        if (closer) begin
          bestd_d = cand_dist;
          best_slot_d = steps_q[SlotW-1:0];
        end
        if (!(steps_inc < count_q)) begin
          head_we = 1'b1;
          head_waddr = code_q;
          head_wdata = {1'b1, closer ? steps_q[SlotW-1:0] : best_slot_q};
          code_d = code_q + CodeW'(1);
        end
      end
      ST_QRD: ;
      ST_QCHK: begin
        nxt_d = next_rd_q;
        idx_d = data_rd_q.idx;
        res_color_d = data_rd_q.idx;
      end
      ST_QD1: ;
      ST_QCMP: begin
        first_d = 1'b0;
        steps_d = steps_inc;
        cur_d = nxt_q[SlotW-1:0];
        if (closer) begin
          bestd_d = cand_dist;
          best_idx_d = idx_q;
          res_color_d = idx_q;
        end else begin
          res_color_d = best_idx_q;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_color_d = res_color_q;
          out_status_d = res_status_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      mode_q <= 1'b1;
      count_q <= '0;
      clr_q <= '0;
      clr_req_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) mode_q <= cfg_wdata_i;
      count_q <= count_d;
      clr_q <= clr_d;
      clr_req_q <= clr_req_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    cidx_q <= cidx_d;
    red_q <= red_d;
    green_q <= green_d;
    blue_q <= blue_d;
    steps_q <= steps_d;
    code_q <= code_d;
    first_q <= first_d;
    cur_q <= cur_d;
    nxt_q <= nxt_d;
    idx_q <= idx_d;
    best_idx_q <= best_idx_d;
    best_slot_q <= best_slot_d;
    bestd_q <= bestd_d;
    res_color_q <= res_color_d;
    res_status_q <= res_status_d;
    out_color_q <= out_color_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o = out_valid_q;
  assign result_color_o = out_color_q;
  assign result_status_o = out_status_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_COLORS))
    else $error("installed count above capacity");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while another is in progress");

  a_beat_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result beat raised outside completion");
`endif

endmodule
